// ===== hw/rtl/png_rgba_pkg.sv =====
`default_nettype none
package png_rgba_pkg;

  // Byte source selected by the controller for each emitted byte
  typedef enum logic [1:0] {
    SRC_HDR,
    SRC_BLK,
    SRC_RAW,
    SRC_TRL
  } src_e;

  localparam logic [1:0]  CFG_WIDTH  = 2'd0;
  localparam logic [1:0]  CFG_HEIGHT = 2'd1;

  localparam logic [12:0] MAX_DIM    = 13'd4096;
  localparam logic [15:0] BLOCK_MAX  = 16'hFFFF;
  localparam logic [16:0] ADLER_MOD  = 17'd65521;
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

  localparam logic [5:0]  HDR_LAST   = 6'd42;
  localparam logic [5:0]  BLK_LAST   = 6'd4;
  localparam logic [5:0]  TRL_LAST   = 6'd19;

  typedef struct packed {
    logic       emit;
    src_e       src;
    logic [5:0] idx;
    logic       filt;
    logic       start;
    logic       load_raw;
    logic       load_pix;
    logic       run_last;
    logic       file_done;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic col_zero;
    logic blk_zero;
    logic blk_one;
    logic last_pixel;
  } sts_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [12:0] clamp_dim(input logic [12:0] v);
    logic [12:0] r;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if (v > MAX_DIM) begin
      r = MAX_DIM;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/png_stored_rgba_encoder_core.sv =====
// PNG encoder for RGBA8 images using stored (uncompressed) deflate blocks.
// Input channel: one colour byte per transfer (R G B A per pixel, raster
// order) on pixel_byte_i with in_valid_i / in_ready_o.
// Output channel: one PNG file byte per transfer on out_byte_o with
// out_valid_o / out_ready_i; run_last_o marks the final byte caused by an
// input byte, file_done_o the final byte of the file.
// Configuration: cfg_index_i 0 sets image width, 1 sets height (0 reads as
// 1, values above 4096 saturate); other indexes are dropped. Geometry is
// latched at the first byte of each file. cfg_ready_o is always high.
// Output: the controller emits one byte per cycle through a single output
// register while out_ready_i is high. An input byte yields one result (two
// with a row filter byte), plus 5 for a block header, 43 for the file
// header and 20 for the trailer; input is taken only when the block is idle.
// A stalled receiver holds the output register; emission pauses and no
// input is taken until the last result of the current byte is loaded.
// Reset returns the block to file start with 1 x 1 geometry.
`default_nettype none
module png_stored_rgba_encoder_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  pixel_byte_i,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [12:0] cfg_data_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        file_done_o
);

  png_rgba_pkg::cmd_t cmd;
  png_rgba_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencer: chooses byte source and advances through the file layout
  png_rgba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: checksums, counters, byte selection and output register
  png_rgba_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_byte_i (pixel_byte_i),
    .out_ready_i  (out_ready_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .file_done_o  (file_done_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/png_rgba_dp.sv =====
`default_nettype none
module png_rgba_dp (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_valid_i,
  input  wire  [1:0]          cfg_index_i,
  input  wire  [12:0]         cfg_data_i,
  input  wire  [7:0]          pixel_byte_i,
  input  wire                 out_ready_i,
  input  png_rgba_pkg::cmd_t  cmd_i,
  output png_rgba_pkg::sts_t  sts_o,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                run_last_o,
  output logic                file_done_o
);

  localparam logic [15:0] BLOCK_MAX_W = png_rgba_pkg::BLOCK_MAX;

  logic [12:0] width_q, height_q, cur_w_q, cur_h_q;
  logic [26:0] raw_q, raw_rem_q;
  logic [31:0] idat_len_q, crc_q;
  logic [7:0]  pix_q;
  logic [15:0] adl_lo_q, adl_hi_q, blk_rem_q;
  logic [13:0] col_q;
  logic [12:0] row_q;
  logic        ovalid_q, run_last_q, file_done_q;
  logic [7:0]  obyte_q;

  logic [14:0] w4;
  logic [27:0] raw_prod, div_y;
  logic [11:0] div_q0;
  logic [16:0] div_r;
  logic [11:0] blocks;
  logic [31:0] idat_len_d, crc_out, crc_in;
  logic [15:0] blk_len, blk_inv;
  logic        blk_final;
  logic [7:0]  byte_d;
  logic        feed, restart;
  logic [16:0] lo_sum, hi_sum;
  logic [15:0] lo_n, hi_n;
  logic        raw_emit;

  assign w4       = {cur_w_q, 2'b00};
  assign raw_prod = {15'd0, cur_h_q} * {13'd0, w4 + 15'd1};

  // Ceiling divide by 65535: y >> 16 plus one correction step
  assign div_y  = {1'b0, raw_q} + 28'd65534;
  assign div_q0 = div_y[27:16];
  assign div_r  = {1'b0, div_y[15:0]} + {5'd0, div_q0};
  assign blocks = div_q0 + {11'd0, (div_r >= {1'b0, BLOCK_MAX_W})};

  assign idat_len_d = 32'd6 + {18'd0, blocks, 2'b00} + {20'd0, blocks} + {5'd0, raw_q};

  assign blk_final = (raw_rem_q[26:16] == 11'd0);
  assign blk_len   = blk_final ? raw_rem_q[15:0] : png_rgba_pkg::BLOCK_MAX;
  assign blk_inv   = ~blk_len;
  assign crc_out   = ~crc_q;

  always_comb begin
    byte_d  = 8'h00;
    feed    = 1'b0;
    restart = 1'b0;
    case (cmd_i.src)
      png_rgba_pkg::SRC_HDR: begin
        feed    = ((cmd_i.idx >= 6'd12) && (cmd_i.idx <= 6'd28)) || (cmd_i.idx >= 6'd37);
        restart = (cmd_i.idx == 6'd12) || (cmd_i.idx == 6'd37);
        case (cmd_i.idx)
          6'd0:  byte_d = 8'h89;
          6'd1:  byte_d = 8'h50;
          6'd2:  byte_d = 8'h4E;
          6'd3:  byte_d = 8'h47;
          6'd4:  byte_d = 8'h0D;
          6'd5:  byte_d = 8'h0A;
          6'd6:  byte_d = 8'h1A;
          6'd7:  byte_d = 8'h0A;
          6'd11: byte_d = 8'h0D;
          6'd12: byte_d = 8'h49;
          6'd13: byte_d = 8'h48;
          6'd14: byte_d = 8'h44;
          6'd15: byte_d = 8'h52;
          6'd18: byte_d = {3'd0, cur_w_q[12:8]};
          6'd19: byte_d = cur_w_q[7:0];
          6'd22: byte_d = {3'd0, cur_h_q[12:8]};
          6'd23: byte_d = cur_h_q[7:0];
          6'd24: byte_d = 8'h08;
          6'd25: byte_d = 8'h06;
          6'd29: byte_d = crc_out[31:24];
          6'd30: byte_d = crc_out[23:16];
          6'd31: byte_d = crc_out[15:8];
          6'd32: byte_d = crc_out[7:0];
          6'd33: byte_d = idat_len_q[31:24];
          6'd34: byte_d = idat_len_q[23:16];
          6'd35: byte_d = idat_len_q[15:8];
          6'd36: byte_d = idat_len_q[7:0];
          6'd37: byte_d = 8'h49;
          6'd38: byte_d = 8'h44;
          6'd39: byte_d = 8'h41;
          6'd40: byte_d = 8'h54;
          6'd41: byte_d = 8'h78;
          6'd42: byte_d = 8'h01;
          default: byte_d = 8'h00;
        endcase
      end
      png_rgba_pkg::SRC_BLK: begin
        feed = 1'b1;
        case (cmd_i.idx)
          6'd0:    byte_d = {7'd0, blk_final};
          6'd1:    byte_d = blk_len[7:0];
          6'd2:    byte_d = blk_len[15:8];
          6'd3:    byte_d = blk_inv[7:0];
          default: byte_d = blk_inv[15:8];
        endcase
      end
      png_rgba_pkg::SRC_RAW: begin
        feed   = 1'b1;
        byte_d = cmd_i.filt ? 8'h00 : pix_q;
      end
      default: begin
        feed    = (cmd_i.idx <= 6'd3) || ((cmd_i.idx >= 6'd12) && (cmd_i.idx <= 6'd15));
        restart = (cmd_i.idx == 6'd12);
        case (cmd_i.idx)
          6'd0:  byte_d = adl_hi_q[15:8];
          6'd1:  byte_d = adl_hi_q[7:0];
          6'd2:  byte_d = adl_lo_q[15:8];
          6'd3:  byte_d = adl_lo_q[7:0];
          6'd4:  byte_d = crc_out[31:24];
          6'd5:  byte_d = crc_out[23:16];
          6'd6:  byte_d = crc_out[15:8];
          6'd7:  byte_d = crc_out[7:0];
          6'd12: byte_d = 8'h49;
          6'd13: byte_d = 8'h45;
          6'd14: byte_d = 8'h4E;
          6'd15: byte_d = 8'h44;
          6'd16: byte_d = crc_out[31:24];
          6'd17: byte_d = crc_out[23:16];
          6'd18: byte_d = crc_out[15:8];
          6'd19: byte_d = crc_out[7:0];
          default: byte_d = 8'h00;
        endcase
      end
    endcase
  end

  assign crc_in   = restart ? png_rgba_pkg::CRC_INIT : crc_q;
  assign raw_emit = cmd_i.emit && (cmd_i.src == png_rgba_pkg::SRC_RAW);

  // Adler-32 sums, one compare and subtract each
  assign lo_sum = {1'b0, adl_lo_q} + {9'd0, byte_d};
  assign lo_n   = (lo_sum >= png_rgba_pkg::ADLER_MOD) ?
                  16'(lo_sum - png_rgba_pkg::ADLER_MOD) : lo_sum[15:0];
  assign hi_sum = {1'b0, adl_hi_q} + {1'b0, lo_n};
  assign hi_n   = (hi_sum >= png_rgba_pkg::ADLER_MOD) ?
                  16'(hi_sum - png_rgba_pkg::ADLER_MOD) : hi_sum[15:0];

  assign sts_o.out_free   = !ovalid_q || out_ready_i;
  assign sts_o.col_zero   = (col_q == 14'd0);
  assign sts_o.blk_zero   = (blk_rem_q == 16'd0);
  assign sts_o.blk_one    = (blk_rem_q == 16'd1);
  assign sts_o.last_pixel = ({1'b0, col_q} + 15'd1 == w4) &&
                            ({1'b0, row_q} + 14'd1 == {1'b0, cur_h_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 13'd1;
      height_q    <= 13'd1;
      cur_w_q     <= 13'd1;
      cur_h_q     <= 13'd1;
      crc_q       <= png_rgba_pkg::CRC_INIT;
      adl_lo_q    <= 16'd1;
      adl_hi_q    <= 16'd0;
      col_q       <= 14'd0;
      row_q       <= 13'd0;
      blk_rem_q   <= 16'd0;
      raw_rem_q   <= 27'd0;
      ovalid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == png_rgba_pkg::CFG_WIDTH)) begin
        width_q <= cfg_data_i;
      end
      if (cfg_valid_i && (cfg_index_i == png_rgba_pkg::CFG_HEIGHT)) begin
        height_q <= cfg_data_i;
      end
      if (cmd_i.start) begin
        cur_w_q   <= png_rgba_pkg::clamp_dim(width_q);
        cur_h_q   <= png_rgba_pkg::clamp_dim(height_q);
        adl_lo_q  <= 16'd1;
        adl_hi_q  <= 16'd0;
        col_q     <= 14'd0;
        row_q     <= 13'd0;
        blk_rem_q <= 16'd0;
      end
      if (cmd_i.load_raw) begin
        raw_rem_q <= raw_q;
      end
      if (cmd_i.emit) begin
        if (feed) begin
          crc_q <= png_rgba_pkg::crc_byte(crc_in, byte_d);
        end
        if ((cmd_i.src == png_rgba_pkg::SRC_BLK) && (cmd_i.idx == png_rgba_pkg::BLK_LAST)) begin
          blk_rem_q <= blk_len;
        end
      end
      if (raw_emit) begin
        adl_lo_q <= lo_n;
        adl_hi_q <= hi_n;
        if (blk_rem_q != 16'd0) begin
          blk_rem_q <= blk_rem_q - 16'd1;
        end
        if (raw_rem_q != 27'd0) begin
          raw_rem_q <= raw_rem_q - 27'd1;
        end
        if (!cmd_i.filt) begin
          if ({1'b0, col_q} + 15'd1 == w4) begin
            col_q <= 14'd0;
            row_q <= row_q + 13'd1;
          end else begin
            col_q <= col_q + 14'd1;
          end
        end
      end
      if (cmd_i.emit) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q      <= raw_prod[26:0];
    idat_len_q <= idat_len_d;
    if (cmd_i.load_pix) begin
      pix_q <= pixel_byte_i;
    end
    if (cmd_i.emit) begin
      obyte_q     <= byte_d;
      run_last_q  <= cmd_i.run_last;
      file_done_q <= cmd_i.file_done;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign run_last_o  = run_last_q;
  assign file_done_o = file_done_q;

endmodule
`default_nettype wire

// ===== hw/rtl/png_rgba_ctrl.sv =====
`default_nettype none
module png_rgba_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  png_rgba_pkg::sts_t  sts_i,
  output png_rgba_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_BLK,
    S_RAW,
    S_TRL
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] idx_q, idx_d;
  logic       filt_q, filt_d;
  logic       in_file_q, in_file_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    filt_d    = filt_q;
    in_file_d = in_file_q;

    cmd_o           = '0;
    cmd_o.idx       = idx_q;
    cmd_o.filt      = filt_q;
    cmd_o.src       = png_rgba_pkg::SRC_RAW;
    cmd_o.emit      = (state_q != S_IDLE) && sts_i.out_free;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_pix = 1'b1;
          idx_d          = 6'd0;
          if (!in_file_q) begin
            cmd_o.start = 1'b1;
            filt_d      = 1'b1;
            state_d     = S_HDR;
          end else begin
            filt_d  = sts_i.col_zero;
            state_d = sts_i.blk_zero ? S_BLK : S_RAW;
          end
        end
      end
      S_HDR: begin
        cmd_o.src = png_rgba_pkg::SRC_HDR;
        if (cmd_o.emit) begin
          idx_d = idx_q + 6'd1;
          if (idx_q == png_rgba_pkg::HDR_LAST) begin
            cmd_o.load_raw = 1'b1;
            in_file_d      = 1'b1;
            idx_d          = 6'd0;
            state_d        = S_BLK;
          end
        end
      end
      S_BLK: begin
        cmd_o.src = png_rgba_pkg::SRC_BLK;
        if (cmd_o.emit) begin
          idx_d = idx_q + 6'd1;
          if (idx_q == png_rgba_pkg::BLK_LAST) begin
            idx_d   = 6'd0;
            state_d = S_RAW;
          end
        end
      end
      S_RAW: begin
        cmd_o.src      = png_rgba_pkg::SRC_RAW;
        cmd_o.run_last = !filt_q && !sts_i.last_pixel;
        if (cmd_o.emit) begin
          idx_d = 6'd0;
          if (filt_q) begin
            // filter byte done: the pixel byte may need a fresh block
            filt_d  = 1'b0;
            state_d = sts_i.blk_one ? S_BLK : S_RAW;
          end else begin
            state_d = sts_i.last_pixel ? S_TRL : S_IDLE;
          end
        end
      end
      S_TRL: begin
        cmd_o.src = png_rgba_pkg::SRC_TRL;
        if (idx_q == png_rgba_pkg::TRL_LAST) begin
          cmd_o.run_last  = 1'b1;
          cmd_o.file_done = 1'b1;
        end
        if (cmd_o.emit) begin
          idx_d = idx_q + 6'd1;
          if (idx_q == png_rgba_pkg::TRL_LAST) begin
            idx_d     = 6'd0;
            in_file_d = 1'b0;
            state_d   = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= 6'd0;
      filt_q    <= 1'b0;
      in_file_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      filt_q    <= filt_d;
      in_file_q <= in_file_d;
    end
  end

endmodule
`default_nettype wire
